// ===== hw/rtl/upd_pkg.sv =====
package upd_pkg;

	// Escape-sequence position within the string.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	// Status codes reported on the end-of-string result.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CUT  = 2'd1;
	localparam logic [1:0] ST_CTRL = 2'd2;

	// Character constants.
	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] UPPER_BASE = 8'h41;
	localparam logic [7:0] LOWER_BASE = 8'h61;
	localparam logic [7:0] CTRL_MAX   = 8'h1F;

	// One raw input character with its end-of-string mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_terminator;
	} upd_item_t;

	// One decoded result, with a flag saying whether the step produced it.
	typedef struct packed {
		logic       valid;
		logic [7:0] out_byte;
		logic       is_end;
		logic [1:0] status;
	} upd_result_t;

	// Hex digit value; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= DIGIT_BASE && c <= DIGIT_BASE + 8'd9) begin
				d = c - DIGIT_BASE;
			end else if (c >= UPPER_BASE && c <= UPPER_BASE + 8'd5) begin
				d = c - UPPER_BASE + 8'd10;
			end else if (c >= LOWER_BASE && c <= LOWER_BASE + 8'd5) begin
				d = c - LOWER_BASE + 8'd10;
			end
			return d[3:0];
		end
	endfunction

endpackage

// ===== hw/rtl/url_percent_decoder.sv =====
// Percent-decoder for a byte stream.
// Slave channel: one raw character per transfer in s_axis_tdata; s_axis_tlast
// marks the terminator transfer, whose data byte is ignored.
// Master channel: one decoded byte per transfer in m_axis_tdata. The result
// answering the terminator has m_axis_tlast high, data zero and the string
// status in m_axis_tuser (0 ok, 1 escape cut short, 2 control byte decoded).
// A '%', a first hex digit and a control-byte escape give no output transfer,
// nor does any byte after an error; the terminator always gives one.
// A result passes from the input register through the combinational decode
// into the output register; the input register loads at the edge that
// accepts its input transfer.
// Throughput: one input transfer per cycle while the receiver does not stall,
// set by the single decode stage that updates the escape state once per item.
// Reset clears both stage valid flags and returns the decoder outside an
// escape with no error recorded. When the receiver stalls, the output
// register holds its result, the input register fills behind it, and
// s_axis_tready then drops until m_axis_tready is seen high.
module url_percent_decoder
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic [1:0] m_axis_tuser   // [1:0] status
);

	upd_item_t   in_item;
	upd_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        fire;
	upd_result_t result;
	logic        out_valid_q;
	upd_result_t out_res_q;

	assign in_item.in_byte       = s_axis_tdata;
	assign in_item.is_terminator = s_axis_tlast;

	// The output register can load when empty or when its result is taken.
	assign advance = !out_valid_q || m_axis_tready;
	assign fire    = valid_s1 && advance;

	upd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	upd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && result.valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire && result.valid) begin
			out_res_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q.out_byte;
	assign m_axis_tlast  = out_res_q.is_end;
	assign m_axis_tuser  = out_res_q.status;

	// Only the end-of-string result carries a status other than ok.
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_OK)
		else $error("status set on a data result");

	// The end-of-string result always carries a zero data byte.
	a_end_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'd0)
		else $error("data byte set on the end result");

	// A terminator in the input stage that moves on always yields a result.
	a_term_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.is_terminator |=> m_axis_tvalid && m_axis_tlast)
		else $error("terminator gave no end result");

endmodule

// ===== hw/rtl/upd_in_reg.sv =====
module upd_in_reg
	import upd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  upd_item_t in_item,
	input  logic      advance,
	output logic      valid_s1,
	output upd_item_t item_s1
);

	// The stage takes a new transfer when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input stage.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// A held item that cannot move on must still be there next cycle.
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled item");

endmodule

// ===== hw/rtl/upd_decode.sv =====
module upd_decode
	import upd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  upd_item_t   item,
	output upd_result_t result
);

	phase_t     phase_q, phase_d;
	logic [3:0] high_nibble_q, high_nibble_d;
	logic [1:0] error_q, error_d;
	logic [3:0] digit;
	logic [7:0] decoded;

	assign digit   = hex_value(item.in_byte);
	assign decoded = {high_nibble_q, digit};

	// Next state of the decoder for the item in the input stage.
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		error_d       = error_q;
		if (item.is_terminator) begin
			phase_d       = PH_IDLE;
			high_nibble_d = 4'd0;
			error_d       = ST_OK;
		end else if (error_q == ST_OK) begin
			unique case (phase_q)
				PH_HIGH: begin
					high_nibble_d = digit;
					phase_d       = PH_LOW;
				end
				PH_LOW: begin
					phase_d       = PH_IDLE;
					high_nibble_d = 4'd0;
					if (decoded <= CTRL_MAX) begin
						error_d = ST_CTRL;
					end
				end
				default: begin
					phase_d = (item.in_byte == PCT_CHAR) ? PH_HIGH : PH_IDLE;
				end
			endcase
		end
	end

	// Result produced by the item in the input stage.
	always_comb begin
		result = '0;
		if (item.is_terminator) begin
			result.valid  = 1'b1;
			result.is_end = 1'b1;
			if (error_q != ST_OK) begin
				result.status = error_q;
			end else if (phase_q == PH_HIGH || phase_q == PH_LOW) begin
				result.status = ST_CUT;
			end else begin
				result.status = ST_OK;
			end
		end else if (error_q == ST_OK) begin
			unique case (phase_q)
				PH_HIGH: begin
					result.valid = 1'b0;
				end
				PH_LOW: begin
					result.valid    = (decoded > CTRL_MAX);
					result.out_byte = decoded;
				end
				default: begin
					result.valid    = (item.in_byte != PCT_CHAR);
					result.out_byte = item.in_byte;
				end
			endcase
		end
	end

	// Decoder state advances once for each item that is passed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			high_nibble_q <= 4'd0;
			error_q       <= ST_OK;
		end else if (fire) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			error_q       <= error_d;
		end
	end

	// A recorded error always leaves the decoder outside an escape.
	a_error_idle: assert property (@(posedge clk) disable iff (!arst_n)
		error_q != ST_OK |-> phase_q == PH_IDLE)
		else $error("error recorded inside an escape");

	// The high digit is held only while the low digit is awaited.
	a_nibble_phase: assert property (@(posedge clk) disable iff (!arst_n)
		high_nibble_q != 4'd0 |-> phase_q == PH_LOW)
		else $error("stale high digit outside an escape");

endmodule

// ===== tb/tb.sv =====
module tb
	import upd_pkg::*;
;

	// Expected decoder output for one master transfer.
	typedef struct {
		logic [7:0] data;
		logic       last;
		logic [1:0] stat;
	} decoded_t;

	// Tracks the escape state of the string and queues the transfers it should yield.
	class decode_predictor;
		phase_t     phase;
		logic [3:0] hi_nib;
		logic [1:0] err;
		decoded_t   expected[$];
		int         faults;

		function new();
			phase  = PH_IDLE;
			hi_nib = 4'd0;
			err    = ST_OK;
			faults = 0;
		endfunction

		// Anything other than a hex digit counts as zero.
		function logic [3:0] digit_of(logic [7:0] c);
			logic [7:0] d;
			d = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
			end
			return d[3:0];
		endfunction

		function void push(logic [7:0] d, logic l, logic [1:0] s);
			decoded_t r;
			r.data = d;
			r.last = l;
			r.stat = s;
			expected.push_back(r);
		endfunction

		// Called once per accepted slave transfer.
		function void note_char(logic [7:0] b, logic t);
			logic [7:0] v;
			if (t) begin
				// A recorded error wins; otherwise an open escape means it was cut short.
				if (err == ST_OK && phase != PH_IDLE) begin
					push(8'd0, 1'b1, ST_CUT);
				end else begin
					push(8'd0, 1'b1, err);
				end
				phase  = PH_IDLE;
				hi_nib = 4'd0;
				err    = ST_OK;
				return;
			end
			if (err != ST_OK) begin
				return;
			end
			case (phase)
				PH_HIGH: begin
					hi_nib = digit_of(b);
					phase  = PH_LOW;
				end
				PH_LOW: begin
					v      = {hi_nib, digit_of(b)};
					phase  = PH_IDLE;
					hi_nib = 4'd0;
					if (v <= CTRL_MAX) begin
						err = ST_CTRL;
					end else begin
						push(v, 1'b0, ST_OK);
					end
				end
				default: begin
					if (b == PCT_CHAR) begin
						phase = PH_HIGH;
					end else begin
						push(b, 1'b0, ST_OK);
					end
				end
			endcase
		endfunction

		// Called once per accepted master transfer.
		function void check_char(logic [7:0] d, logic l, logic [1:0] s);
			decoded_t r;
			if (expected.size() == 0) begin
				$display("%0t: unexpected transfer, actual data %h last %b user %0d",
					$time, d, l, s);
				faults++;
				return;
			end
			r = expected.pop_front();
			if (d !== r.data || l !== r.last || s !== r.stat) begin
				$display("%0t: mismatch, expected data %h last %b user %0d,",
					$time, r.data, r.last, r.stat,
					" actual data %h last %b user %0d", d, l, s);
				faults++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;

	decode_predictor board;
	bit              steady = 1'b0;
	int              sent_items = 0;

	url_percent_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#5000000;
		$display("url_percent_decoder regression: fail");
		$finish;
	end

	// Receiver: check every accepted result and stall now and then.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 9);
		end
	end

	// Presents one item, with random idle cycles in front, and waits for its transfer.
	task automatic send_item(input logic [7:0] b, input logic t);
		while (!steady && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			s_axis_tlast  <= 1'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= t;
		do @(posedge clk); while (!s_axis_tready);
		board.note_char(b, t);
		sent_items++;
	endtask

	// Hex digit for a nibble, with letters in either case.
	function automatic logic [7:0] digit_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + n;
		end
		return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	task automatic send_escape(input logic [7:0] v);
		send_item(PCT_CHAR, 1'b0);
		send_item(digit_char(v[7:4]), 1'b0);
		send_item(digit_char(v[3:0]), 1'b0);
	endtask

	// One random string: mostly plain bytes and valid escapes, with some control
	// escapes, escapes with arbitrary digits and escapes cut short at the end.
	task automatic send_string();
		int         n;
		int         pick;
		logic [7:0] v;
		n = $urandom_range(10);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 58) begin
				v = 8'($urandom);
				if (v == PCT_CHAR) begin
					v = 8'hA5;
				end
				send_item(v, 1'b0);
			end else if (pick < 87) begin
				send_escape(8'($urandom_range(8'hFF, 8'h20)));
			end else if (pick < 93) begin
				send_escape(8'($urandom_range(CTRL_MAX)));
			end else begin
				send_item(PCT_CHAR, 1'b0);
				send_item(8'($urandom), 1'b0);
				send_item(8'($urandom), 1'b0);
			end
		end
		pick = $urandom_range(99);
		if (pick < 6) begin
			send_item(PCT_CHAR, 1'b0);
		end else if (pick < 12) begin
			send_item(PCT_CHAR, 1'b0);
			send_item(digit_char(4'($urandom_range(15))), 1'b0);
		end
		send_item(8'($urandom), 1'b1);
	endtask

	initial begin
		logic [8:0] script[$];
		board = new();
		// Directed strings; bit 8 marks the terminator.
		script = '{
			9'h100,                                   // empty string
			9'h000, 9'h0FF, 9'h1A5,                   // raw zero and 0xFF pass through
			9'h025, 9'h034, 9'h031,                   // escape giving 'A'
			9'h025, 9'h066, 9'h046,                   // mixed-case letters, high byte
			9'h025, 9'h037, 9'h025,                   // second percent counts as zero
			9'h025, 9'h032, 9'h030,                   // lowest byte above the control range
			9'h100,
			9'h025, 9'h034, 9'h100,                   // cut short after the high digit
			9'h025, 9'h100,                           // cut short straight after the percent
			9'h025, 9'h031, 9'h046, 9'h025, 9'h100    // top of the control range, then dropped
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			send_item(script[i][7:0], script[i][8]);
		end

		// Random strings, with a stretch where neither side idles.
		while (sent_items < 1400) begin
			steady = (sent_items >= 500 && sent_items < 800);
			send_string();
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		// Drain, then leave room for a stray transfer to show up.
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (board.faults == 0) begin
			$display("url_percent_decoder regression: pass");
		end else begin
			$display("url_percent_decoder regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/upd_pkg.sv
hw/rtl/upd_in_reg.sv
hw/rtl/upd_decode.sv
hw/rtl/url_percent_decoder.sv
tb/tb.sv
